/* sv/at_response_line_matcher_macros.svh */
// Assertion macros for the modem response line matcher.
`ifndef AT_RESPONSE_LINE_MATCHER_MACROS_SVH
`define AT_RESPONSE_LINE_MATCHER_MACROS_SVH

`ifndef ASSERT_OFF
// Check prop on every clock edge outside reset.
`define ARLM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check prop on every clock edge, reset included.
`define ARLM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ARLM_ASSERT(lbl, clk, rst_n, prop, msg)
`define ARLM_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* sv/arlm_pkg.sv */
package arlm_pkg;

    // Default sizes
    localparam int PATTERN_MAX_DEF = 16;
    localparam int LINE_MAX_DEF    = 256;

    // Expected text held in two 64-bit registers
    localparam int PAT_BYTES = 16;
    localparam int PAT_LEN_W = 5;
    localparam int PAT_IDX_W = $clog2(PAT_BYTES);

    // Stream and config widths
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 64;

    // Line terminators
    localparam logic [7:0] CHAR_LF = 8'h0a;
    localparam logic [7:0] CHAR_CR = 8'h0d;

    // "ERROR", first character at index 0
    localparam int ERR_LEN = 5;
    localparam logic [ERR_LEN-1:0][7:0] ERR_TEXT = {8'h52, 8'h4f, 8'h52, 8'h52, 8'h45};

    typedef enum logic [1:0] {
        MODE_BYTE = 2'd0,
        MODE_ARM  = 2'd1,
        MODE_TICK = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ERROR   = 2'd1,
        ST_TIMEOUT = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_PATTERN_LENGTH = 2'd2
    } cfg_index_t;

endpackage

/* sv/at_response_line_matcher.sv */
// An accepted request that settles a result raises m_tvalid in the next cycle.
// Throughput: one request per cycle; each request is settled by one pass of
// byte compares between the input handshake and the result register.
// s_tready stays high while the result register is empty or being drained.
// Reset: synchronous, active low; clears the arm state, line state, window,
// configuration registers and the result register.
`include "at_response_line_matcher_macros.svh"

module at_response_line_matcher #(
    parameter int PATTERN_MAX = arlm_pkg::PATTERN_MAX_DEF,
    parameter int LINE_MAX    = arlm_pkg::LINE_MAX_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // request channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [arlm_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte, [39:8] timeout_ticks
    input  logic [arlm_pkg::S_TUSER_W-1:0] s_tuser,   // [1:0] mode
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [arlm_pkg::M_TDATA_W-1:0] m_tdata,   // [1:0] status, [7:2] zero
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [arlm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [arlm_pkg::CFG_DAT_W-1:0] cfg_data
);
    import arlm_pkg::*;

    localparam int LCW     = $clog2(LINE_MAX);
    localparam int CMPW    = (LCW > PAT_LEN_W) ? LCW : PAT_LEN_W;
    localparam int LC_LAST = LINE_MAX - 1;

    // Configuration
    logic [63:0]            pattern_low_reg;
    logic [63:0]            pattern_high_reg;
    logic [PAT_LEN_W-1:0]   pattern_length_reg;

    // Line and arm state
    logic                   waiting_reg, waiting_next;
    logic [31:0]            ticks_left_reg, ticks_left_next;
    logic [LCW-1:0]         line_count_reg, line_count_next;
    logic [PATTERN_MAX-1:0][7:0] recent_reg, recent_next;
    logic                   saw_expected_reg, saw_expected_next;
    logic                   saw_error_reg, saw_error_next;

    // Result register
    logic                   m_tvalid_reg, m_tvalid_next;
    status_t                m_status_reg, m_status_next;

    // Request fields
    logic                   s_accept;
    mode_t                  in_mode;
    logic [7:0]             in_byte;
    logic [31:0]            in_ticks;

    logic                   is_eol;
    logic [LCW-1:0]         lc_inc;
    logic [PATTERN_MAX-1:0][7:0] win_shift;
    logic [PAT_BYTES-1:0][7:0]   pat_bytes;
    logic [PAT_LEN_W-1:0]   len_cap;
    logic [PAT_LEN_W-1:0]   eff_len;
    logic [PAT_LEN_W-1:0]   eff_len_m1;
    logic [PAT_BYTES-1:0]   cand;
    logic                   pat_hit;
    logic                   err_hit;
    logic [31:0]            tick_dec;
    logic                   res_fire;
    status_t                res_status;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {{(M_TDATA_W-2){1'b0}}, m_status_reg};

    assign in_mode   = mode_t'(s_tuser[1:0]);
    assign in_byte   = s_tdata[7:0];
    assign in_ticks  = s_tdata[39:8];

    assign is_eol    = (in_byte == CHAR_LF) || (in_byte == CHAR_CR);
    assign lc_inc    = line_count_reg + 1'b1;
    assign win_shift = {recent_reg[PATTERN_MAX-2:0], in_byte};
    assign pat_bytes = {pattern_high_reg, pattern_low_reg};

    // Clamp the pattern length to the stored bytes and the window depth
    always_comb begin
        len_cap = (pattern_length_reg > PAT_LEN_W'(PAT_BYTES)) ?
                  PAT_LEN_W'(PAT_BYTES) : pattern_length_reg;
        eff_len = ({1'b0, len_cap} > (PAT_LEN_W+1)'(PATTERN_MAX)) ?
                  PAT_LEN_W'(PATTERN_MAX) : len_cap;
    end
    assign eff_len_m1 = eff_len - 1'b1;

    // Compare the shifted window against every pattern length in parallel
    for (genvar gn = 1; gn <= PAT_BYTES; gn++) begin : g_len
        if (gn <= PATTERN_MAX) begin : g_fit
            always_comb begin
                cand[gn-1] = 1'b1;
                for (int i = 0; i < gn; i++) begin
                    if (win_shift[gn-1-i] != pat_bytes[i]) cand[gn-1] = 1'b0;
                end
            end
        end else begin : g_over
            assign cand[gn-1] = 1'b0;
        end
    end

    assign pat_hit = (eff_len != '0) && cand[eff_len_m1[PAT_IDX_W-1:0]] &&
                     (CMPW'(lc_inc) >= CMPW'(eff_len));

    // Look for "ERROR" at the tail of the window
    always_comb begin
        err_hit = (lc_inc >= LCW'(ERR_LEN));
        for (int i = 0; i < ERR_LEN; i++) begin
            if (win_shift[ERR_LEN-1-i] != ERR_TEXT[i]) err_hit = 1'b0;
        end
    end

    assign tick_dec = (ticks_left_reg != '0) ? ticks_left_reg - 1'b1 : ticks_left_reg;

    // Next state and result for one request
    always_comb begin
        waiting_next      = waiting_reg;
        ticks_left_next   = ticks_left_reg;
        line_count_next   = line_count_reg;
        recent_next       = recent_reg;
        saw_expected_next = saw_expected_reg;
        saw_error_next    = saw_error_reg;
        res_fire          = 1'b0;
        res_status        = ST_OK;
        if (s_accept) begin
            case (in_mode)
                MODE_BYTE: begin
                    if (is_eol) begin
                        if (line_count_reg != '0) begin
                            if (waiting_reg && saw_expected_reg) begin
                                res_fire     = 1'b1;
                                res_status   = ST_OK;
                                waiting_next = 1'b0;
                            end else if (waiting_reg && saw_error_reg) begin
                                res_fire     = 1'b1;
                                res_status   = ST_ERROR;
                                waiting_next = 1'b0;
                            end
                            line_count_next   = '0;
                            saw_expected_next = 1'b0;
                            saw_error_next    = 1'b0;
                        end
                    end else if (line_count_reg < LCW'(LC_LAST)) begin
                        recent_next     = win_shift;
                        line_count_next = lc_inc;
                        if (pat_hit) saw_expected_next = 1'b1;
                        if (err_hit) saw_error_next = 1'b1;
                    end
                end
                MODE_ARM: begin
                    if (eff_len == '0) begin
                        waiting_next    = 1'b0;
                        ticks_left_next = '0;
                        res_fire        = 1'b1;
                        res_status      = ST_OK;
                    end else if (in_ticks == '0) begin
                        waiting_next    = 1'b0;
                        ticks_left_next = '0;
                        res_fire        = 1'b1;
                        res_status      = ST_TIMEOUT;
                    end else begin
                        waiting_next    = 1'b1;
                        ticks_left_next = in_ticks;
                    end
                end
                MODE_TICK: begin
                    if (waiting_reg) begin
                        ticks_left_next = tick_dec;
                        if (tick_dec == '0) begin
                            waiting_next = 1'b0;
                            res_fire     = 1'b1;
                            res_status   = ST_TIMEOUT;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Load the result register, drain it on handshake
    always_comb begin
        m_status_next = res_fire ? res_status : m_status_reg;
        if (res_fire) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
            waiting_reg        <= 1'b0;
            ticks_left_reg     <= '0;
            line_count_reg     <= '0;
            recent_reg         <= '0;
            saw_expected_reg   <= 1'b0;
            saw_error_reg      <= 1'b0;
            m_tvalid_reg       <= 1'b0;
            m_status_reg       <= ST_OK;
        end else begin
            // Take configuration writes; unknown indexes are dropped
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PATTERN_LOW:    pattern_low_reg    <= cfg_data;
                    CFG_PATTERN_HIGH:   pattern_high_reg   <= cfg_data;
                    CFG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[PAT_LEN_W-1:0];
                    default: ;
                endcase
            end
            waiting_reg      <= waiting_next;
            ticks_left_reg   <= ticks_left_next;
            line_count_reg   <= line_count_next;
            recent_reg       <= recent_next;
            saw_expected_reg <= saw_expected_next;
            saw_error_reg    <= saw_error_next;
            m_tvalid_reg     <= m_tvalid_next;
            m_status_reg     <= m_status_next;
        end
    end

    // Armed state always has time left
    `ARLM_ASSERT(a_armed_ticks, aclk, aresetn, waiting_reg |-> ticks_left_reg != '0, "armed with no ticks left")
    // Line length never passes the drop limit
    `ARLM_ASSERT(a_line_cap, aclk, aresetn, line_count_reg <= LCW'(LC_LAST), "line count past limit")
    // Match flags belong to a non-empty line
    `ARLM_ASSERT(a_flags_line, aclk, aresetn, (saw_expected_reg || saw_error_reg) |-> line_count_reg != '0, "match flag on empty line")
    // A matched line end while armed reports OK next cycle
    `ARLM_ASSERT(a_eol_ok, aclk, aresetn, (s_accept && in_mode == MODE_BYTE && is_eol && line_count_reg != '0 && waiting_reg && saw_expected_reg) |=> (m_tvalid_reg && m_status_reg == ST_OK), "matched line did not report OK")

endmodule

/* dv/at_response_line_matcher_checker.sv */
module at_response_line_matcher_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [arlm_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte, [39:8] timeout_ticks
    input  logic [arlm_pkg::S_TUSER_W-1:0] s_tuser,   // [1:0] mode
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [arlm_pkg::M_TDATA_W-1:0] m_tdata,   // [1:0] status, [7:2] zero
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [arlm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [arlm_pkg::CFG_DAT_W-1:0] cfg_data,
    output int                             mismatch_count,
    output int                             status_backlog
);
    import arlm_pkg::*;

    // Shadow of the configuration registers
    logic [63:0]         pat_lo;
    logic [63:0]         pat_hi;
    logic [PAT_LEN_W-1:0] pat_len;

    // Shadow of the arm and line state
    logic        armed;
    logic [31:0] ticks_left;
    int          line_len;
    logic [7:0]  window [PATTERN_MAX_DEF];
    logic        hit_pattern;
    logic        hit_error;

    status_t     status_q[$];
    int          err_total;

    task automatic report_mismatch(string msg);
        err_total++;
        if (err_total <= 100) begin
            $display("%0t at_response_line_matcher checker: %s", $time, msg);
        end
    endtask

    function automatic logic [7:0] pattern_char(int i);
        return (i < 8) ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8];
    endfunction

    // Advance the shadow state by one request and queue the status it causes
    function automatic void advance_matcher(logic [1:0] mode, logic [7:0] ch,
                                            logic [31:0] tmo);
        int   len;
        logic hit;
        len = (pat_len > PAT_BYTES) ? PAT_BYTES : int'(pat_len);
        if (len > PATTERN_MAX_DEF) len = PATTERN_MAX_DEF;
        case (mode)
            MODE_BYTE: begin
                if (ch == CHAR_LF || ch == CHAR_CR) begin
                    // Close a non-empty line; report only while armed
                    if (line_len != 0) begin
                        if (armed && hit_pattern) begin
                            status_q.push_back(ST_OK);
                            armed = 1'b0;
                        end else if (armed && hit_error) begin
                            status_q.push_back(ST_ERROR);
                            armed = 1'b0;
                        end
                        line_len    = 0;
                        hit_pattern = 1'b0;
                        hit_error   = 1'b0;
                    end
                end else if (line_len < LINE_MAX_DEF - 1) begin
                    // Shift the byte into the window, newest at index zero
                    for (int i = PATTERN_MAX_DEF - 1; i > 0; i--) window[i] = window[i-1];
                    window[0] = ch;
                    line_len++;
                    if (len != 0 && len <= line_len) begin
                        hit = 1'b1;
                        for (int i = 0; i < len; i++) begin
                            if (window[len-1-i] != pattern_char(i)) hit = 1'b0;
                        end
                        if (hit) hit_pattern = 1'b1;
                    end
                    if (line_len >= ERR_LEN) begin
                        hit = 1'b1;
                        for (int i = 0; i < ERR_LEN; i++) begin
                            if (window[ERR_LEN-1-i] != ERR_TEXT[i]) hit = 1'b0;
                        end
                        if (hit) hit_error = 1'b1;
                    end
                end
            end
            MODE_ARM: begin
                if (len == 0) begin
                    armed      = 1'b0;
                    ticks_left = '0;
                    status_q.push_back(ST_OK);
                end else if (tmo == 0) begin
                    armed      = 1'b0;
                    ticks_left = '0;
                    status_q.push_back(ST_TIMEOUT);
                end else begin
                    armed      = 1'b1;
                    ticks_left = tmo;
                end
            end
            MODE_TICK: begin
                if (armed) begin
                    if (ticks_left != 0) ticks_left--;
                    if (ticks_left == 0) begin
                        armed = 1'b0;
                        status_q.push_back(ST_TIMEOUT);
                    end
                end
            end
            default: begin
            end
        endcase
    endfunction

    // Watch all three channels on the rising edge
    always @(posedge aclk) begin
        status_t want;
        if (!aresetn) begin
            pat_lo      = '0;
            pat_hi      = '0;
            pat_len     = '0;
            armed       = 1'b0;
            ticks_left  = '0;
            line_len    = 0;
            hit_pattern = 1'b0;
            hit_error   = 1'b0;
            foreach (window[i]) window[i] = 8'h00;
            status_q.delete();
        end else begin
            // Compare the result against the oldest expected status
            if (m_tvalid && m_tready) begin
                if (status_q.size() == 0) begin
                    report_mismatch($sformatf("result %0d with no status expected",
                                              m_tdata[1:0]));
                end else begin
                    want = status_q.pop_front();
                    if (m_tdata[1:0] != want) begin
                        report_mismatch($sformatf("status %0d, expected %s",
                                                  m_tdata[1:0], want.name()));
                    end
                    if (m_tdata[M_TDATA_W-1:2] != '0) begin
                        report_mismatch($sformatf("padding bits 0x%0h not zero",
                                                  m_tdata[M_TDATA_W-1:2]));
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_PATTERN_LOW:    pat_lo  = cfg_data;
                    CFG_PATTERN_HIGH:   pat_hi  = cfg_data;
                    CFG_PATTERN_LENGTH: pat_len = cfg_data[PAT_LEN_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (s_tvalid && s_tready) begin
                advance_matcher(s_tuser, s_tdata[7:0], s_tdata[39:8]);
            end
        end
        status_backlog <= status_q.size();
        mismatch_count <= err_total;
    end

endmodule

/* dv/at_response_line_matcher_test.sv */
module at_response_line_matcher_test;
    import arlm_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int IDLE_LIMIT  = 1000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 200;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;   // [7:0] data_byte, [39:8] timeout_ticks
    logic [S_TUSER_W-1:0]   s_tuser;   // [1:0] mode
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;   // [1:0] status, [7:2] zero
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DAT_W-1:0]   cfg_data;

    int mismatch_count;
    int status_backlog;
    int idle_cycles;
    bit gaps_on = 1'b1;

    // Stimulus copy of the configured text, byte 0 lowest
    logic [127:0] pat_text;
    int           pat_eff;

    at_response_line_matcher i_dut (.*);

    at_response_line_matcher_checker i_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // End the run when nothing moves on any channel for too long
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("at_response_line_matcher_test: done, errors");
        $finish;
    end

    // Stall the result side in short bursts
    initial begin
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (gaps_on && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 5);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Send one request, with an occasional gap in front of it
    task automatic push_request(logic [1:0] mode, logic [7:0] ch, logic [31:0] tmo);
        int gap;
        if (gaps_on && $urandom_range(0, 9) == 0) begin
            gap = $urandom_range(1, 5);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {tmo, ch};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [63:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [63:0] lo, logic [63:0] hi, logic [4:0] len);
        write_reg(CFG_PATTERN_LOW, lo);
        write_reg(CFG_PATTERN_HIGH, hi);
        write_reg(CFG_PATTERN_LENGTH, 64'(len));
        pat_text = {hi, lo};
        pat_eff  = (len > PAT_BYTES) ? PAT_BYTES : int'(len);
    endtask

    // Stop sending and let every expected status come back
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (status_backlog != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Random text bytes with no line terminators in them
    function automatic logic [63:0] text_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        for (int k = 0; k < 8; k++) begin
            if (w[8*k +: 8] == CHAR_LF || w[8*k +: 8] == CHAR_CR) w[8*k +: 8] ^= 8'h20;
        end
        return w;
    endfunction

    initial begin
        int          sent;
        int          pick;
        int          roll;
        int          body_len;
        int          pos;
        int          burst;
        logic [31:0] tmo;
        logic [7:0]  ch;
        logic [1:0]  mode_pick;
        logic [7:0]  line_q[$];

        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: expected text "OK"
        configure(64'h4b4f, {$urandom, $urandom}, 5'd2);
        push_request(MODE_TICK, 8'h00, 32'h0);            // tick while disarmed
        push_request(MODE_UNUSED, 8'hff, 32'hffff_ffff);  // unused mode
        push_request(MODE_BYTE, CHAR_LF, 32'h0);          // empty line
        push_request(MODE_ARM, 8'h00, 32'h0);             // zero timeout
        push_request(MODE_ARM, 8'h00, 32'hffff_ffff);
        for (int k = 0; k < ERR_LEN; k++) push_request(MODE_BYTE, ERR_TEXT[k], 32'h0);
        push_request(MODE_BYTE, CHAR_CR, 32'h0);
        // Arm again in the middle of a line
        push_request(MODE_ARM, 8'h00, 32'd5);
        push_request(MODE_BYTE, pat_text[7:0], 32'h0);
        push_request(MODE_ARM, 8'h00, 32'd9);
        push_request(MODE_BYTE, pat_text[15:8], 32'h0);
        push_request(MODE_BYTE, CHAR_LF, 32'h0);
        // Re-arm while armed, then run out
        push_request(MODE_ARM, 8'h00, 32'd3);
        push_request(MODE_TICK, 8'h00, 32'h0);
        push_request(MODE_ARM, 8'h00, 32'd2);
        push_request(MODE_TICK, 8'h00, 32'h0);
        push_request(MODE_TICK, 8'h00, 32'h0);
        // Line end while disarmed, zero byte included
        push_request(MODE_BYTE, 8'h00, 32'h0);
        push_request(MODE_BYTE, 8'hff, 32'h0);
        push_request(MODE_BYTE, CHAR_CR, 32'h0);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            case (ph)
                0: configure(text_word(), text_word(), 5'd31);
                1: configure({$urandom, $urandom}, {$urandom, $urandom}, 5'd0);
                2: configure(text_word(), text_word(), 5'd1);
                3: configure('1, '1, 5'd16);
                4: configure('0, '0, 5'd5);
                5: configure(text_word(), text_word(), 5'($urandom_range(2, 15)));
                6: configure(text_word(), text_word(), 5'($urandom_range(17, 30)));
                default: configure(text_word(), text_word(), 5'($urandom_range(2, 8)));
            endcase
            gaps_on = (ph != PHASES - 1);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 22) begin
                    // Arm: mostly short timeouts, now and then zero or huge
                    tmo  = $urandom_range(1, 30);
                    roll = $urandom_range(0, 9);
                    if (roll == 0) tmo = '0;
                    else if (roll == 1) tmo = $urandom;
                    push_request(MODE_ARM, 8'($urandom), tmo);
                    sent++;
                end else if (pick < 77) begin
                    // Build a line around the expected text and/or ERROR
                    line_q.delete();
                    if ((ph == 0 && sent == 0) || $urandom_range(0, 99) == 0)
                        body_len = $urandom_range(250, 270);
                    else
                        body_len = $urandom_range(0, 20);
                    repeat (body_len) begin
                        ch = $urandom;
                        if (ch == CHAR_LF || ch == CHAR_CR) ch ^= 8'h20;
                        line_q.push_back(ch);
                    end
                    if ($urandom_range(0, 99) < 45) begin
                        pos = $urandom_range(0, line_q.size());
                        for (int k = 0; k < pat_eff; k++)
                            line_q.insert(pos + k, pat_text[8*k +: 8]);
                    end
                    if ($urandom_range(0, 99) < 25) begin
                        pos = $urandom_range(0, line_q.size());
                        for (int k = 0; k < ERR_LEN; k++) line_q.insert(pos + k, ERR_TEXT[k]);
                    end
                    roll = $urandom_range(0, 3);
                    line_q.push_back(roll[0] ? CHAR_CR : CHAR_LF);
                    if (roll == 0) line_q.push_back(CHAR_LF);
                    foreach (line_q[k]) push_request(MODE_BYTE, line_q[k], $urandom);
                    sent += line_q.size();
                end else if (pick < 93) begin
                    burst = $urandom_range(1, 8);
                    repeat (burst) push_request(MODE_TICK, 8'($urandom), $urandom);
                    sent += burst;
                end else begin
                    // Noise: any mode, any data
                    mode_pick = $urandom_range(MODE_BYTE, MODE_UNUSED);
                    push_request(mode_pick, 8'($urandom), $urandom);
                    sent++;
                end
            end
        end

        drain_results();
        if (mismatch_count == 0)
            $display("at_response_line_matcher_test: done, clean");
        else
            $display("at_response_line_matcher_test: done, errors");
        $finish;
    end

endmodule
